### design/sbsm_pkg.sv
// Shared types and constants for the serial bank switch mapper.
`default_nettype none

package sbsm_pkg;

  localparam int unsigned BANK_W    = 5;
  localparam int unsigned COUNT_W   = 6;
  localparam int unsigned ROM_W     = 19;
  localparam int unsigned RAM_BYTES = 8192;
  localparam int unsigned RAM_AW    = $clog2(RAM_BYTES);
  localparam int unsigned PRG_SHIFT = $clog2(16384);
  localparam int unsigned CHR_SHIFT = $clog2(4096);

  localparam logic [1:0] ACT_CPU_READ  = 2'd0;
  localparam logic [1:0] ACT_CPU_WRITE = 2'd1;
  localparam logic [1:0] ACT_PPU_READ  = 2'd2;

  localparam logic [2:0] KIND_RAM   = 3'd0;
  localparam logic [2:0] KIND_PRG   = 3'd1;
  localparam logic [2:0] KIND_CHR   = 3'd2;
  localparam logic [2:0] KIND_WRITE = 3'd3;
  localparam logic [2:0] KIND_NONE  = 3'd4;

  localparam logic CFG_PRG_COUNT = 1'b0;
  localparam logic CFG_CHR_COUNT = 1'b1;

  localparam logic [4:0] LOAD_EMPTY   = 5'h10;
  localparam logic [4:0] CTRL_RESET   = 5'h0C;
  localparam logic [5:0] PRG_CNT_RST  = 6'd2;
  localparam logic [4:0] CHR_CNT_RST  = 5'd1;

  localparam logic [1:0] REG_CONTROL  = 2'd0;
  localparam logic [1:0] REG_CHR_LOW  = 2'd1;
  localparam logic [1:0] REG_CHR_HIGH = 2'd2;
  localparam logic [1:0] REG_PRG      = 2'd3;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] bus_address;
    logic [7:0]  write_value;
  } sbsm_in_t;

  typedef struct packed {
    logic [2:0]       result_kind;
    logic [7:0]       read_data;
    logic [ROM_W-1:0] rom_address;
    logic [1:0]       mirroring;
  } sbsm_out_t;

  typedef struct packed {
    logic               start;
    logic [BANK_W-1:0]  dividend;
    logic [COUNT_W-1:0] divisor;
  } sbsm_mod_req_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_DONE = 3'b100
  } sbsm_state_e;

endpackage

`default_nettype wire

### design/sbsm_mod_unit.sv
// Bit-serial restoring remainder unit for bank index modulo bank count.
`default_nettype none

module sbsm_mod_unit
  import sbsm_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire sbsm_mod_req_t      req_i,
  output logic                    done_o,
  output logic [COUNT_W-1:0]      rem_o
);

  localparam int unsigned CNT_W = $clog2(BANK_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(BANK_W - 1);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [BANK_W-1:0]   dvd_q, dvd_d;
  logic [COUNT_W-1:0]  dsr_q, dsr_d;
  logic [COUNT_W-1:0]  rem_q, rem_d;
  logic [COUNT_W:0]    trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    rem_d  = rem_q;
    trial  = {rem_q, dvd_q[BANK_W-1]};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = req_i.dividend;
      dsr_d  = req_i.divisor;
      rem_d  = '0;
    end else if (busy_q) begin
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = COUNT_W'(trial - {1'b0, dsr_q});
      end else begin
        rem_d = trial[COUNT_W-1:0];
      end
      dvd_d = {dvd_q[BANK_W-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LAST_STEP) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = (dsr_q == '0) ? '0 : rem_q;

endmodule

`default_nettype wire

### design/serial_bank_switch_mapper.sv
// Top level of the serial bank switch mapper: register file, work RAM, sequencer.
//
// Input channel in_valid_i/in_ready_o carries one bus access word: CPU read,
// CPU write or PPU pattern read. Output channel out_valid_o/out_ready_i
// carries one result word per access: kind, RAM byte, ROM offset, mirroring.
// Configuration writes (bank counts) go through cfg_we_i/cfg_index_i/
// cfg_data_i and take effect at the next edge; write them only while idle.
// CPU ROM reads and PPU reads are reduced modulo the PRG bank count or twice
// the CHR bank count by a bit-serial remainder unit, one quotient bit per
// cycle over five bits; the sequencer waits in its divide state for the
// unit's done flag, then loads the result from its done state. RAM reads and
// writes, serial register writes and unmapped accesses go straight to the
// done state (work RAM read data is registered at acceptance).
// One access is in work at a time: the next word is taken the cycle after
// the result enters the output register.
// A stalled receiver holds the output register; a finished access then
// waits in the sequencer until the register frees up.
// Reset empties the serial load register, sets control to 0x0C, clears the
// bank selects and windows, and restores bank counts 2 and 1. Work RAM
// content is not cleared.
`default_nettype none

module serial_bank_switch_mapper
  import sbsm_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire sbsm_in_t     in_item_i,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output sbsm_out_t         out_item_o,
  input  wire logic         cfg_we_i,
  input  wire logic         cfg_index_i,
  input  wire logic [5:0]   cfg_data_i
);

  sbsm_state_e          state_q, state_d;
  logic [COUNT_W-1:0]   prg_cnt_q;
  logic [4:0]           chr_cnt_q;
  logic [4:0]           load_q, load_d;
  logic [4:0]           ctrl_q, ctrl_d;
  logic [4:0]           chr_lo_q, chr_lo_d;
  logic [4:0]           chr_hi_q, chr_hi_d;
  logic [4:0]           prg_sel_q, prg_sel_d;
  logic [4:0]           win_lo_q, win_lo_d;
  logic [4:0]           win_hi_q, win_hi_d;
  logic [2:0]           kind_q, kind_d;
  logic [14:0]          off_q, off_d;
  logic [7:0]           rdata_q;
  logic [7:0]           work_ram_q [RAM_BYTES];
  logic                 out_valid_q;
  sbsm_out_t            out_q;

  logic                 accept;
  logic                 ram_hit;
  logic                 high_hit;
  logic [RAM_AW-1:0]    ram_idx;
  logic                 ram_we;
  logic                 ram_re;
  logic                 out_free;
  logic [4:0]           shifted;
  logic                 rederive;
  logic [4:0]           chr_bank;
  logic [4:0]           prg_win_sel;
  sbsm_mod_req_t        mod_req;
  logic                 mod_done;
  logic [COUNT_W-1:0]   mod_rem;
  logic [ROM_W-1:0]     rom_calc;

  function automatic logic [9:0] derive(input logic [4:0] ctrl, input logic [4:0] sel,
                                        input logic [COUNT_W-1:0] cnt);
    logic [4:0] lo;
    logic [4:0] hi;
    logic [COUNT_W-1:0] last;
    last = cnt - 1'b1;
    case (ctrl[3:2])
      2'd2: begin
        lo = '0;
        hi = sel & 5'h0F;
      end
      2'd3: begin
        lo = sel & 5'h0F;
        hi = last[4:0];
      end
      default: begin
        lo = sel & 5'h0E;
        hi = sel & 5'h0E;
      end
    endcase
    return {lo, hi};
  endfunction

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign ram_hit    = (in_item_i.bus_address[15:13] == 3'b011);
  assign high_hit   = in_item_i.bus_address[15];
  assign ram_idx    = in_item_i.bus_address[RAM_AW-1:0];
  assign ram_we     = accept && (in_item_i.action == ACT_CPU_WRITE) && ram_hit;
  assign ram_re     = accept && (in_item_i.action == ACT_CPU_READ) && ram_hit;
  assign out_free   = !out_valid_q || out_ready_i;
  assign shifted    = {in_item_i.write_value[0], load_q[4:1]};

  assign prg_win_sel = (ctrl_q[3] && in_item_i.bus_address[14]) ? win_hi_q : win_lo_q;
  assign chr_bank = ctrl_q[4] ? (in_item_i.bus_address[12] ? chr_hi_q : chr_lo_q)
                              : (chr_lo_q & 5'h1E);

  always_comb begin
    state_d   = state_q;
    load_d    = load_q;
    ctrl_d    = ctrl_q;
    chr_lo_d  = chr_lo_q;
    chr_hi_d  = chr_hi_q;
    prg_sel_d = prg_sel_q;
    win_lo_d  = win_lo_q;
    win_hi_d  = win_hi_q;
    kind_d    = kind_q;
    off_d     = off_q;
    rederive  = 1'b0;
    mod_req   = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_DONE;
          kind_d  = KIND_NONE;
          case (in_item_i.action)
            ACT_CPU_READ: begin
              if (ram_hit) begin
                kind_d = KIND_RAM;
              end else if (high_hit) begin
                kind_d = KIND_PRG;
                off_d  = ctrl_q[3] ? {1'b0, in_item_i.bus_address[13:0]}
                                   : in_item_i.bus_address[14:0];
                mod_req.start    = 1'b1;
                mod_req.dividend = prg_win_sel;
                mod_req.divisor  = prg_cnt_q;
                state_d          = ST_DIV;
              end
            end
            ACT_CPU_WRITE: begin
              if (ram_hit) begin
                kind_d = KIND_WRITE;
              end else if (high_hit) begin
                kind_d = KIND_WRITE;
                if (in_item_i.write_value[7]) begin
                  load_d   = LOAD_EMPTY;
                  ctrl_d   = ctrl_q | CTRL_RESET;
                  rederive = 1'b1;
                end else if (!load_q[0]) begin
                  load_d = shifted;
                end else begin
                  load_d = LOAD_EMPTY;
                  case (in_item_i.bus_address[14:13])
                    REG_CONTROL: begin
                      ctrl_d   = shifted;
                      rederive = 1'b1;
                    end
                    REG_CHR_LOW:  chr_lo_d = shifted;
                    REG_CHR_HIGH: chr_hi_d = shifted;
                    REG_PRG: begin
                      prg_sel_d = shifted;
                      rederive  = 1'b1;
                    end
                    default: load_d = LOAD_EMPTY;
                  endcase
                end
              end
            end
            ACT_PPU_READ: begin
              kind_d = KIND_CHR;
              off_d  = {2'b00, (ctrl_q[4] && in_item_i.bus_address[12])
                               ? {1'b0, in_item_i.bus_address[11:0]}
                               : in_item_i.bus_address[12:0]};
              mod_req.start    = 1'b1;
              mod_req.dividend = chr_bank;
              mod_req.divisor  = {chr_cnt_q, 1'b0};
              state_d          = ST_DIV;
            end
            default: kind_d = KIND_NONE;
          endcase
          if (rederive) begin
            {win_lo_d, win_hi_d} = derive(ctrl_d, prg_sel_d, prg_cnt_q);
          end
        end
      end
      ST_DIV: begin
        if (mod_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    if (kind_q == KIND_PRG) begin
      rom_calc = ROM_W'({mod_rem, {PRG_SHIFT{1'b0}}}) + ROM_W'(off_q);
    end else begin
      rom_calc = ROM_W'({mod_rem, {CHR_SHIFT{1'b0}}}) + ROM_W'(off_q[12:0]);
    end
  end

  sbsm_mod_unit u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .done_o (mod_done),
    .rem_o  (mod_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      prg_cnt_q   <= PRG_CNT_RST;
      chr_cnt_q   <= CHR_CNT_RST;
      load_q      <= LOAD_EMPTY;
      ctrl_q      <= CTRL_RESET;
      chr_lo_q    <= '0;
      chr_hi_q    <= '0;
      prg_sel_q   <= '0;
      win_lo_q    <= '0;
      win_hi_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      load_q    <= load_d;
      ctrl_q    <= ctrl_d;
      chr_lo_q  <= chr_lo_d;
      chr_hi_q  <= chr_hi_d;
      prg_sel_q <= prg_sel_d;
      win_lo_q  <= win_lo_d;
      win_hi_q  <= win_hi_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_PRG_COUNT: prg_cnt_q <= cfg_data_i;
          CFG_CHR_COUNT: chr_cnt_q <= cfg_data_i[4:0];
          default:       prg_cnt_q <= prg_cnt_q;
        endcase
      end
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    off_q  <= off_d;
    if (state_q == ST_DONE && out_free) begin
      out_q.result_kind <= kind_q;
      out_q.read_data   <= (kind_q == KIND_RAM) ? rdata_q : '0;
      out_q.rom_address <= (kind_q == KIND_PRG || kind_q == KIND_CHR) ? rom_calc : '0;
      out_q.mirroring   <= ctrl_q[1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      work_ram_q[ram_idx] <= in_item_i.write_value;
    end
    if (ram_re) begin
      rdata_q <= work_ram_q[ram_idx];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.result_kind <= KIND_NONE))
    else $error("result kind out of range");

  a_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.result_kind != KIND_RAM) |-> (out_item_o.read_data == '0))
    else $error("read data set for a non-RAM result");

  a_load_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_q != '0)
    else $error("serial load register lost its marker bit");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("second word accepted while one is in work");

endmodule

`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for serial_bank_switch_mapper: directed and random bus access words.
`timescale 1ns / 100ps

module tb_top;
  import sbsm_pkg::*;

  localparam logic [1:0] ACT_NONE      = 2'd3;
  localparam logic [1:0] PRG_FIX_FIRST = 2'd2;
  localparam logic [1:0] PRG_FIX_LAST  = 2'd3;
  localparam int unsigned STALL_LIMIT  = 1000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned ITEMS        = 1400;

  logic        clk_i;
  logic        rst_ni    = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  sbsm_in_t    in_item   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  sbsm_out_t   out_item;
  logic        cfg_we    = 1'b0;
  logic        cfg_index = CFG_PRG_COUNT;
  logic [5:0]  cfg_data  = '0;

  // mapper state as predicted from the accepted words
  logic [4:0]  shift_reg;
  logic [4:0]  ctrl;
  logic [4:0]  chr_bank_lo;
  logic [4:0]  chr_bank_hi;
  logic [4:0]  prg_sel;
  logic [4:0]  win_lo;
  logic [4:0]  win_hi;
  logic [5:0]  prg_count;
  logic [4:0]  chr_count;
  logic [7:0]  ram_image [RAM_BYTES];
  bit          ram_written [RAM_BYTES];
  int unsigned written_list[$];

  sbsm_out_t   pending_results[$];
  int unsigned errors;
  int unsigned items_sent;
  int unsigned burst_left;
  bit          tx_idle_en;
  bit          rx_stall_en;
  logic [15:0] rx_pattern;
  int unsigned rx_pattern_left;
  int unsigned stall_cycles;

  serial_bank_switch_mapper dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned mod_bank(int unsigned bank, int unsigned count);
    if (count == 0) return 0;
    return bank % count;
  endfunction

  function void rederive_windows();
    logic [5:0] last_bank;
    last_bank = prg_count - 6'd1;
    case (ctrl[3:2])
      PRG_FIX_FIRST: begin
        win_lo = '0;
        win_hi = prg_sel & 5'h0F;
      end
      PRG_FIX_LAST: begin
        win_lo = prg_sel & 5'h0F;
        win_hi = last_bank[4:0];
      end
      default: begin
        win_lo = prg_sel & 5'h0E;
        win_hi = win_lo;
      end
    endcase
  endfunction

  function automatic logic [18:0] prg_offset(logic [15:0] a);
    int unsigned bank;
    int unsigned off;
    if (ctrl[3]) begin
      if (a < 16'hC000) begin
        bank = win_lo;
        off  = a - 16'h8000;
      end else begin
        bank = win_hi;
        off  = a - 16'hC000;
      end
    end else begin
      bank = win_lo;
      off  = a & 16'h7FFF;
    end
    return 19'(16384 * mod_bank(bank, prg_count) + off);
  endfunction

  function automatic logic [18:0] chr_offset(logic [12:0] a);
    int unsigned cnt4;
    cnt4 = 2 * chr_count;
    if (ctrl[4]) begin
      if (a < 13'h1000) return 19'(4096 * mod_bank(chr_bank_lo, cnt4) + a);
      return 19'(4096 * mod_bank(chr_bank_hi, cnt4) + (a & 13'h0FFF));
    end
    return 19'(4096 * mod_bank(chr_bank_lo & 5'h1E, cnt4) + a);
  endfunction

  function void shift_serial(logic [15:0] a, logic [7:0] v);
    logic full;
    if (v[7]) begin
      shift_reg = LOAD_EMPTY;
      ctrl      = ctrl | CTRL_RESET;
      rederive_windows();
      return;
    end
    full      = shift_reg[0];
    shift_reg = {v[0], shift_reg[4:1]};
    if (!full) return;
    case (a[14:13])
      REG_CONTROL: begin
        ctrl = shift_reg;
        rederive_windows();
      end
      REG_CHR_LOW:  chr_bank_lo = shift_reg;
      REG_CHR_HIGH: chr_bank_hi = shift_reg;
      default: begin
        prg_sel = shift_reg;
        rederive_windows();
      end
    endcase
    shift_reg = LOAD_EMPTY;
  endfunction

  function automatic sbsm_out_t map_access(sbsm_in_t w);
    sbsm_out_t   r;
    logic [15:0] a;
    int unsigned idx;
    r             = '0;
    r.result_kind = KIND_NONE;
    a             = w.bus_address;
    idx           = (a - 16'h6000) & (RAM_BYTES - 1);
    case (w.action)
      ACT_CPU_READ: begin
        if (a >= 16'h6000 && a <= 16'h7FFF) begin
          r.result_kind = KIND_RAM;
          r.read_data   = ram_image[idx];
        end else if (a >= 16'h8000) begin
          r.result_kind = KIND_PRG;
          r.rom_address = prg_offset(a);
        end
      end
      ACT_CPU_WRITE: begin
        if (a >= 16'h6000 && a <= 16'h7FFF) begin
          ram_image[idx] = w.write_value;
          if (!ram_written[idx]) begin
            ram_written[idx] = 1'b1;
            written_list.push_back(idx);
          end
          r.result_kind = KIND_WRITE;
        end else if (a >= 16'h8000) begin
          shift_serial(a, w.write_value);
          r.result_kind = KIND_WRITE;
        end
      end
      ACT_PPU_READ: begin
        r.result_kind = KIND_CHR;
        r.rom_address = chr_offset(a[12:0]);
      end
      default: ;
    endcase
    r.mirroring = ctrl[1:0];
    return r;
  endfunction

  function automatic sbsm_in_t make_word(logic [1:0] act, logic [15:0] a, logic [7:0] v);
    sbsm_in_t w;
    w.action      = act;
    w.bus_address = a;
    w.write_value = v;
    return w;
  endfunction

  task automatic send_word(sbsm_in_t w);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = 0;
      if (tx_idle_en && $urandom_range(0, 3) != 0) gap = $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid <= 1'b1;
    in_item  <= w;
    do @(posedge clk_i); while (in_ready !== 1'b1);
    pending_results.push_back(map_access(w));
    if (!(w.action == ACT_NONE ||
          (w.action == ACT_CPU_WRITE && w.bus_address < 16'h6000))) items_sent++;
  endtask

  // five serial writes to one register; break_at >= 0 aborts with a load reset there
  task automatic load_serial(logic [1:0] sel, logic [4:0] val, int break_at);
    logic [7:0] v;
    for (int i = 0; i < 5; i++) begin
      v    = {1'b0, 7'($urandom)};
      v[0] = val[i];
      if (i == break_at) v[7] = 1'b1;
      send_word(make_word(ACT_CPU_WRITE, {1'b1, sel, 13'($urandom)}, v));
      if (i == break_at) break;
    end
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_bank_counts(logic [5:0] prg, logic [5:0] chr);
    settle();
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_PRG_COUNT;
    cfg_data  <= prg;
    @(negedge clk_i);
    cfg_index <= CFG_CHR_COUNT;
    cfg_data  <= chr;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    prg_count = prg;
    chr_count = chr[4:0];
  endtask

  task automatic test_unmapped();
    send_word(make_word(ACT_CPU_READ, 16'h0000, 8'h00));
    send_word(make_word(ACT_CPU_READ, 16'h5FFF, 8'hFF));
    send_word(make_word(ACT_CPU_WRITE, 16'h5FFF, 8'hAA));
    send_word(make_word(ACT_NONE, 16'hFFFF, 8'hFF));
  endtask

  task automatic test_work_ram();
    send_word(make_word(ACT_CPU_WRITE, 16'h6000, 8'hFF));
    send_word(make_word(ACT_CPU_WRITE, 16'h7FFF, 8'h00));
    send_word(make_word(ACT_CPU_READ, 16'h6000, 8'h00));
    send_word(make_word(ACT_CPU_READ, 16'h7FFF, 8'hFF));
  endtask

  task automatic test_rom_translation();
    send_word(make_word(ACT_CPU_READ, 16'h8000, 8'h00));
    send_word(make_word(ACT_CPU_READ, 16'hFFFF, 8'h00));
    send_word(make_word(ACT_PPU_READ, 16'h0000, 8'h00));
    send_word(make_word(ACT_PPU_READ, 16'hFFFF, 8'h00));
  endtask

  task automatic test_load_reset();
    send_word(make_word(ACT_CPU_WRITE, 16'h8000, 8'h80));
    send_word(make_word(ACT_CPU_READ, 16'hC000, 8'h00));
  endtask

  task automatic test_serial_load();
    load_serial(REG_CONTROL, 5'h1B, -1);
    send_word(make_word(ACT_PPU_READ, 16'h1000, 8'h00));
    send_word(make_word(ACT_CPU_READ, 16'h8000, 8'h00));
  endtask

  task automatic run_random(int unsigned n);
    int unsigned stop_at;
    logic [15:0] a;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          if ($urandom_range(0, 7) == 0) load_serial(2'($urandom), 5'($urandom),
                                                     $urandom_range(0, 4));
          else load_serial(2'($urandom), 5'($urandom), -1);
        end
        3: send_word(make_word(ACT_CPU_READ, {1'b1, 15'($urandom)}, 8'($urandom)));
        4, 9: send_word(make_word(ACT_PPU_READ, 16'($urandom), 8'($urandom)));
        5: send_word(make_word(ACT_CPU_WRITE, 16'h6000 + 13'($urandom), 8'($urandom)));
        6: begin
          if (written_list.size() == 0) begin
            a = 16'h6000 + 13'($urandom);
            send_word(make_word(ACT_CPU_WRITE, a, 8'($urandom)));
          end else begin
            a = 16'h6000 + 16'(written_list[$urandom_range(0, written_list.size() - 1)]);
            send_word(make_word(ACT_CPU_READ, a, 8'($urandom)));
          end
        end
        7: send_word(make_word(2'($urandom_range(0, 1)), 16'($urandom_range(0, 16'h5FFF)),
                               8'($urandom)));
        default: begin
          if ($urandom_range(0, 1) == 0)
            send_word(make_word(ACT_NONE, 16'($urandom), 8'($urandom)));
          else
            send_word(make_word(ACT_CPU_WRITE, {1'b1, 15'($urandom)}, 8'($urandom)));
        end
      endcase
    end
  endtask

  task automatic test_bank_counts();
    int unsigned per_phase;
    per_phase = ITEMS / 8;
    set_bank_counts(6'd1, 6'd1);
    tx_idle_en = 1'b1; rx_stall_en = 1'b1;
    run_random(per_phase);
    set_bank_counts(6'd32, 6'd16);
    tx_idle_en = 1'b0; rx_stall_en = 1'b0;
    run_random(per_phase);
    set_bank_counts(6'd63, 6'd63);
    tx_idle_en = 1'b1; rx_stall_en = 1'b0;
    run_random(per_phase);
    set_bank_counts(6'd0, 6'd0);
    tx_idle_en = 1'b0; rx_stall_en = 1'b1;
    run_random(per_phase);
    repeat (4) begin
      set_bank_counts(6'($urandom_range(1, 32)), 6'($urandom_range(1, 16)));
      tx_idle_en = 1'($urandom_range(0, 1)); rx_stall_en = 1'($urandom_range(0, 1));
      run_random(per_phase);
    end
    settle();
  endtask

  // receiver: with stalls enabled, ready follows a 16-bit pattern, reloaded at random
  always @(negedge clk_i) begin
    if (rx_pattern_left == 0) begin
      rx_pattern_left = 16;
      case ($urandom_range(0, 3))
        0: rx_pattern = '1;
        1: rx_pattern = 16'($urandom);
        2: rx_pattern = 16'($urandom) | 16'($urandom);
        default: rx_pattern = 16'($urandom) & 16'($urandom) & 16'($urandom);
      endcase
    end
    out_ready <= rx_pattern[0] | ~rx_stall_en;
    rx_pattern = {rx_pattern[0], rx_pattern[15:1]};
    rx_pattern_left--;
  end

  task automatic show_diff(string what, logic [31:0] want, logic [31:0] got);
    $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, what, want, got);
    errors++;
  endtask

  always @(posedge clk_i) begin
    sbsm_out_t want;
    if (rst_ni && out_valid === 1'b1 && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word %p", $time, out_item);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_item.result_kind !== want.result_kind)
          show_diff("result_kind", 32'(want.result_kind), 32'(out_item.result_kind));
        if (out_item.read_data !== want.read_data)
          show_diff("read_data", 32'(want.read_data), 32'(out_item.read_data));
        if (out_item.rom_address !== want.rom_address)
          show_diff("rom_address", 32'(want.rom_address), 32'(out_item.rom_address));
        if (out_item.mirroring !== want.mirroring)
          show_diff("mirroring", 32'(want.mirroring), 32'(out_item.mirroring));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    errors          = 0;
    items_sent      = 0;
    burst_left      = 0;
    stall_cycles    = 0;
    rx_pattern      = '1;
    rx_pattern_left = 0;
    tx_idle_en      = 1'b1;
    rx_stall_en     = 1'b1;
    shift_reg       = LOAD_EMPTY;
    ctrl            = CTRL_RESET;
    chr_bank_lo     = '0;
    chr_bank_hi     = '0;
    prg_sel         = '0;
    win_lo          = '0;
    win_hi          = '0;
    prg_count       = PRG_CNT_RST;
    chr_count       = CHR_CNT_RST;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_unmapped();
    test_work_ram();
    test_rom_translation();
    test_load_reset();
    test_serial_load();
    test_bank_counts();
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

### filelist.f
design/sbsm_pkg.sv
design/sbsm_mod_unit.sv
design/serial_bank_switch_mapper.sv
tb/tb_top.sv
